// ===== rtl/core/gga_sentence_position_parser_top_macros.svh =====
// Assertion helpers used by the core RTL.
`ifndef GGA_SENTENCE_POSITION_PARSER_TOP_MACROS_SVH
`define GGA_SENTENCE_POSITION_PARSER_TOP_MACROS_SVH

// Same-cycle implication.
`define GGA_POS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GGA_POS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/gga_pos_pkg.sv =====
package gga_pos_pkg;

   localparam int WHOLE_W    = 17;
   localparam int FRAC6_W    = 20;
   localparam int DEG_W      = 10;
   localparam int MM_W       = 7;
   localparam int X_W        = 27;
   localparam int Q_W        = 21;
   localparam int MAG_W      = 30;
   localparam int COORD_W    = 31;
   localparam int DEG_PROD_W = 35;
   localparam int Q_PROD_W   = 51;

   // whole / 100 as (whole * DEG_RECIP) >> DEG_SHIFT, exact below 199728
   localparam logic [17:0] DEG_RECIP = 18'd167773;
   localparam int          DEG_SHIFT = 24;
   localparam logic [6:0]  DEG_SCALE = 7'd100;

   // y / 15 as (y * RECIP15) >> RECIP15_SHIFT, exact below 2^29 / 13
   localparam logic [25:0] RECIP15       = 26'd35791395;
   localparam int          RECIP15_SHIFT = 29;

   localparam logic [19:0] MICRO      = 20'd1000000;
   localparam logic [4:0]  ROUND_BIAS = 5'd30;

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_W     = 8'h57;

   localparam logic [3:0] FIELD_ID  = 4'd0;
   localparam logic [3:0] FIELD_LAT = 4'd2;
   localparam logic [3:0] FIELD_NS  = 4'd3;
   localparam logic [3:0] FIELD_LON = 4'd4;
   localparam logic [3:0] FIELD_EW  = 4'd5;
   localparam logic [3:0] FIELD_MAX = 4'd15;

   localparam logic [2:0] ID_LEN = 3'd6;
   localparam logic [2:0] ID_MAX = 3'd7;

   typedef struct packed {
      logic [WHOLE_W-1:0] whole;
      logic [FRAC6_W-1:0] frac;
      logic               neg;
   } coord_type;

   typedef struct packed {
      logic      ok;
      coord_type lat;
      coord_type lon;
   } line_type;

   function automatic logic [7:0] id_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h24;
         3'd1:    c = 8'h47;
         3'd2:    c = 8'h50;
         3'd3:    c = 8'h47;
         3'd4:    c = 8'h47;
         3'd5:    c = 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // scale a fraction of n digits to six digits
   function automatic logic [FRAC6_W-1:0] frac_scale(input logic [2:0] n);
      logic [FRAC6_W-1:0] s;
      case (n)
         3'd0:    s = 20'd1000000;
         3'd1:    s = 20'd100000;
         3'd2:    s = 20'd10000;
         3'd3:    s = 20'd1000;
         3'd4:    s = 20'd100;
         3'd5:    s = 20'd10;
         default: s = 20'd1;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/gga_pos_parse.sv =====
module gga_pos_parse #(
   parameter int FRACTION_DIGITS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_fire,
   input  logic [7:0]           rx_byte,
   output logic                 line_fire,
   output gga_pos_pkg::line_type line_data
);

   localparam int FracW = $clog2(10 ** FRACTION_DIGITS);

   typedef enum logic [2:0] {
      NUM_INT  = 3'b001,
      NUM_FRAC = 3'b010,
      NUM_STOP = 3'b100
   } num_stage_type;

   logic [3:0]                      field_number_ff, field_number_in;
   logic [2:0]                      id_position_ff, id_position_in;
   logic                            id_matches_ff, id_matches_in;
   logic [gga_pos_pkg::WHOLE_W-1:0] whole_accum_ff, whole_accum_in;
   logic [FracW-1:0]                fraction_accum_ff, fraction_accum_in;
   logic [2:0]                      fraction_count_ff, fraction_count_in;
   logic [2:0]                      whole_count_ff, whole_count_in;
   num_stage_type                   number_stage_ff, number_stage_in;
   logic                            field_bad_ff, field_bad_in;
   logic                            field_seen_ff, field_seen_in;
   logic [gga_pos_pkg::WHOLE_W-1:0] lat_whole_ff, lat_whole_in;
   logic [gga_pos_pkg::FRAC6_W-1:0] lat_frac_ff, lat_frac_in;
   logic                            lat_ok_ff, lat_ok_in;
   logic [gga_pos_pkg::WHOLE_W-1:0] lon_whole_ff, lon_whole_in;
   logic [gga_pos_pkg::FRAC6_W-1:0] lon_frac_ff, lon_frac_in;
   logic                            lon_ok_ff, lon_ok_in;
   logic [7:0]                      ind_char_ff, ind_char_in;
   logic [1:0]                      ind_len_ff, ind_len_in;
   logic                            south_ff, south_in;
   logic                            west_ff, west_in;

   logic                            is_nl, is_comma, is_dot, is_digit;
   logic [3:0]                      digit;
   logic [gga_pos_pkg::FRAC6_W-1:0] frac6;
   logic                            field_ok, single;
   logic                            fin_id_matches;
   logic [gga_pos_pkg::WHOLE_W-1:0] fin_lat_whole, fin_lon_whole;
   logic [gga_pos_pkg::FRAC6_W-1:0] fin_lat_frac, fin_lon_frac;
   logic                            fin_lat_ok, fin_lon_ok, fin_south, fin_west;

   assign is_nl    = rx_byte == gga_pos_pkg::CHAR_NL;
   assign is_comma = rx_byte == gga_pos_pkg::CHAR_COMMA;
   assign is_dot   = rx_byte == gga_pos_pkg::CHAR_DOT;
   assign is_digit = rx_byte >= gga_pos_pkg::CHAR_ZERO && rx_byte <= gga_pos_pkg::CHAR_NINE;
   assign digit    = rx_byte[3:0];

   assign frac6    = gga_pos_pkg::FRAC6_W'(gga_pos_pkg::FRAC6_W'(fraction_accum_ff) *
                     gga_pos_pkg::frac_scale(fraction_count_ff));
   assign field_ok = field_seen_ff && !field_bad_ff;
   assign single   = ind_len_ff == 2'd1;

   // field values as they stand once the current field is closed
   always_comb begin
      fin_id_matches = id_matches_ff;
      fin_lat_whole  = lat_whole_ff;
      fin_lat_frac   = lat_frac_ff;
      fin_lat_ok     = lat_ok_ff;
      fin_lon_whole  = lon_whole_ff;
      fin_lon_frac   = lon_frac_ff;
      fin_lon_ok     = lon_ok_ff;
      fin_south      = south_ff;
      fin_west       = west_ff;
      case (field_number_ff)
         gga_pos_pkg::FIELD_ID: begin
            if (id_position_ff != gga_pos_pkg::ID_LEN) fin_id_matches = 1'b0;
         end
         gga_pos_pkg::FIELD_LAT: begin
            fin_lat_whole = whole_accum_ff;
            fin_lat_frac  = frac6;
            fin_lat_ok    = field_ok;
         end
         gga_pos_pkg::FIELD_NS: begin
            fin_south = single && ind_char_ff == gga_pos_pkg::CHAR_S;
         end
         gga_pos_pkg::FIELD_LON: begin
            fin_lon_whole = whole_accum_ff;
            fin_lon_frac  = frac6;
            fin_lon_ok    = field_ok;
         end
         gga_pos_pkg::FIELD_EW: begin
            fin_west = single && ind_char_ff == gga_pos_pkg::CHAR_W;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      field_number_in   = field_number_ff;
      id_position_in    = id_position_ff;
      id_matches_in     = id_matches_ff;
      whole_accum_in    = whole_accum_ff;
      fraction_accum_in = fraction_accum_ff;
      fraction_count_in = fraction_count_ff;
      whole_count_in    = whole_count_ff;
      number_stage_in   = number_stage_ff;
      field_bad_in      = field_bad_ff;
      field_seen_in     = field_seen_ff;
      lat_whole_in      = lat_whole_ff;
      lat_frac_in       = lat_frac_ff;
      lat_ok_in         = lat_ok_ff;
      lon_whole_in      = lon_whole_ff;
      lon_frac_in       = lon_frac_ff;
      lon_ok_in         = lon_ok_ff;
      ind_char_in       = ind_char_ff;
      ind_len_in        = ind_len_ff;
      south_in          = south_ff;
      west_in           = west_ff;

      if (byte_fire) begin
         if (is_nl || is_comma) begin
            whole_accum_in    = '0;
            fraction_accum_in = '0;
            fraction_count_in = '0;
            whole_count_in    = '0;
            number_stage_in   = NUM_INT;
            field_bad_in      = 1'b0;
            field_seen_in     = 1'b0;
            ind_char_in       = '0;
            ind_len_in        = '0;
         end
         if (is_nl) begin
            field_number_in = gga_pos_pkg::FIELD_ID;
            id_position_in  = '0;
            id_matches_in   = 1'b1;
            lat_ok_in       = 1'b0;
            lon_ok_in       = 1'b0;
            south_in        = 1'b0;
            west_in         = 1'b0;
         end else if (is_comma) begin
            id_matches_in = fin_id_matches;
            lat_whole_in  = fin_lat_whole;
            lat_frac_in   = fin_lat_frac;
            lat_ok_in     = fin_lat_ok;
            lon_whole_in  = fin_lon_whole;
            lon_frac_in   = fin_lon_frac;
            lon_ok_in     = fin_lon_ok;
            south_in      = fin_south;
            west_in       = fin_west;
            if (field_number_ff != gga_pos_pkg::FIELD_MAX)
               field_number_in = field_number_ff + 4'd1;
         end else begin
            field_seen_in = 1'b1;
            case (field_number_ff)
               gga_pos_pkg::FIELD_ID: begin
                  if (id_position_ff >= gga_pos_pkg::ID_LEN ||
                      rx_byte != gga_pos_pkg::id_char(id_position_ff))
                     id_matches_in = 1'b0;
                  if (id_position_ff != gga_pos_pkg::ID_MAX)
                     id_position_in = id_position_ff + 3'd1;
               end
               gga_pos_pkg::FIELD_LAT, gga_pos_pkg::FIELD_LON: begin
                  case (number_stage_ff)
                     NUM_INT: begin
                        if (is_digit) begin
                           if (whole_count_ff >= 3'd5) begin
                              field_bad_in    = 1'b1;
                              number_stage_in = NUM_STOP;
                           end else begin
                              whole_accum_in = gga_pos_pkg::WHOLE_W'(whole_accum_ff * 17'd10) +
                                               gga_pos_pkg::WHOLE_W'(digit);
                              whole_count_in = whole_count_ff + 3'd1;
                           end
                        end else if (is_dot) begin
                           number_stage_in = NUM_FRAC;
                        end else begin
                           number_stage_in = NUM_STOP;
                        end
                     end
                     NUM_FRAC: begin
                        if (is_digit) begin
                           if (fraction_count_ff < 3'(FRACTION_DIGITS)) begin
                              fraction_accum_in = FracW'(fraction_accum_ff * FracW'(10)) +
                                                  FracW'(digit);
                              fraction_count_in = fraction_count_ff + 3'd1;
                           end
                        end else begin
                           number_stage_in = NUM_STOP;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               gga_pos_pkg::FIELD_NS, gga_pos_pkg::FIELD_EW: begin
                  if (ind_len_ff == 2'd0) ind_char_in = rx_byte;
                  if (ind_len_ff != 2'd2) ind_len_in = ind_len_ff + 2'd1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_number_ff   <= gga_pos_pkg::FIELD_ID;
         id_position_ff    <= '0;
         id_matches_ff     <= 1'b1;
         whole_accum_ff    <= '0;
         fraction_accum_ff <= '0;
         fraction_count_ff <= '0;
         whole_count_ff    <= '0;
         number_stage_ff   <= NUM_INT;
         field_bad_ff      <= 1'b0;
         field_seen_ff     <= 1'b0;
         lat_ok_ff         <= 1'b0;
         lon_ok_ff         <= 1'b0;
         ind_char_ff       <= '0;
         ind_len_ff        <= '0;
         south_ff          <= 1'b0;
         west_ff           <= 1'b0;
      end else begin
         field_number_ff   <= field_number_in;
         id_position_ff    <= id_position_in;
         id_matches_ff     <= id_matches_in;
         whole_accum_ff    <= whole_accum_in;
         fraction_accum_ff <= fraction_accum_in;
         fraction_count_ff <= fraction_count_in;
         whole_count_ff    <= whole_count_in;
         number_stage_ff   <= number_stage_in;
         field_bad_ff      <= field_bad_in;
         field_seen_ff     <= field_seen_in;
         lat_ok_ff         <= lat_ok_in;
         lon_ok_ff         <= lon_ok_in;
         ind_char_ff       <= ind_char_in;
         ind_len_ff        <= ind_len_in;
         south_ff          <= south_in;
         west_ff           <= west_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_whole_ff <= lat_whole_in;
      lat_frac_ff  <= lat_frac_in;
      lon_whole_ff <= lon_whole_in;
      lon_frac_ff  <= lon_frac_in;
   end

   assign line_fire          = byte_fire && is_nl && fin_id_matches;
   assign line_data.ok       = field_number_ff >= gga_pos_pkg::FIELD_EW &&
                               fin_lat_ok && fin_lon_ok;
   assign line_data.lat.whole = fin_lat_whole;
   assign line_data.lat.frac  = fin_lat_frac;
   assign line_data.lat.neg   = fin_south;
   assign line_data.lon.whole = fin_lon_whole;
   assign line_data.lon.frac  = fin_lon_frac;
   assign line_data.lon.neg   = fin_west;

endmodule

// ===== rtl/core/gga_pos_conv.sv =====
`include "gga_sentence_position_parser_top_macros.svh"

module gga_pos_conv (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    line_fire,
   input  gga_pos_pkg::line_type                   line_data,
   output logic                                    in_ready,
   output logic                                    out_valid,
   input  logic                                    out_stall,
   output logic signed [gga_pos_pkg::COORD_W-1:0] out_lat,
   output logic signed [gga_pos_pkg::COORD_W-1:0] out_lon,
   output logic                                    out_ok
);

   localparam int Stages = 7;
   localparam int Lanes  = 2;

   logic [Stages-1:0] v_ff, v_in;
   logic [Stages-1:0] rdy;

   logic                            ok_ff [Stages];

   logic [gga_pos_pkg::WHOLE_W-1:0] whole0_ff [Lanes];
   logic [gga_pos_pkg::FRAC6_W-1:0] frac0_ff  [Lanes];
   logic                            neg0_ff   [Lanes];

   logic [gga_pos_pkg::DEG_W-1:0]   deg1_ff   [Lanes];
   logic [gga_pos_pkg::WHOLE_W-1:0] whole1_ff [Lanes];
   logic [gga_pos_pkg::FRAC6_W-1:0] frac1_ff  [Lanes];
   logic                            neg1_ff   [Lanes];

   logic [gga_pos_pkg::DEG_W-1:0]   deg2_ff   [Lanes];
   logic [gga_pos_pkg::MM_W-1:0]    mm2_ff    [Lanes];
   logic [gga_pos_pkg::FRAC6_W-1:0] frac2_ff  [Lanes];
   logic                            neg2_ff   [Lanes];

   logic [gga_pos_pkg::DEG_W-1:0]   deg3_ff   [Lanes];
   logic [gga_pos_pkg::X_W-1:0]     x3_ff     [Lanes];
   logic                            neg3_ff   [Lanes];

   logic [gga_pos_pkg::DEG_W-1:0]   deg4_ff   [Lanes];
   logic [gga_pos_pkg::Q_W-1:0]     q4_ff     [Lanes];
   logic                            neg4_ff   [Lanes];

   logic [gga_pos_pkg::MAG_W-1:0]   mag5_ff   [Lanes];
   logic                            neg5_ff   [Lanes];

   logic [gga_pos_pkg::COORD_W-1:0] out6_ff   [Lanes];

   logic [gga_pos_pkg::DEG_PROD_W-1:0] deg_prod [Lanes];
   logic [gga_pos_pkg::WHOLE_W-1:0]    hund     [Lanes];
   logic [gga_pos_pkg::WHOLE_W-1:0]    rem      [Lanes];
   logic [gga_pos_pkg::X_W-1:0]        x_sum    [Lanes];
   logic [gga_pos_pkg::Q_PROD_W-1:0]   q_prod   [Lanes];
   logic [gga_pos_pkg::MAG_W-1:0]      mag_sum  [Lanes];
   logic [gga_pos_pkg::COORD_W-1:0]    mag_ext  [Lanes];

   // a stage takes a beat when it is empty or its successor moves on
   always_comb begin
      rdy[Stages-1] = !v_ff[Stages-1] || !out_stall;
      for (int i = Stages - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (rdy[0]) v_in[0] = line_fire;
      for (int i = 1; i < Stages; i++) begin
         if (rdy[i]) v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         deg_prod[l] = gga_pos_pkg::DEG_PROD_W'(whole0_ff[l]) *
                       gga_pos_pkg::DEG_PROD_W'(gga_pos_pkg::DEG_RECIP);
         hund[l]     = gga_pos_pkg::WHOLE_W'(deg1_ff[l]) *
                       gga_pos_pkg::WHOLE_W'(gga_pos_pkg::DEG_SCALE);
         rem[l]      = whole1_ff[l] - hund[l];
         x_sum[l]    = gga_pos_pkg::X_W'(mm2_ff[l]) * gga_pos_pkg::X_W'(gga_pos_pkg::MICRO) +
                       gga_pos_pkg::X_W'(frac2_ff[l]) +
                       gga_pos_pkg::X_W'(gga_pos_pkg::ROUND_BIAS);
         q_prod[l]   = gga_pos_pkg::Q_PROD_W'(x3_ff[l][gga_pos_pkg::X_W-1:2]) *
                       gga_pos_pkg::Q_PROD_W'(gga_pos_pkg::RECIP15);
         mag_sum[l]  = gga_pos_pkg::MAG_W'(deg4_ff[l]) *
                       gga_pos_pkg::MAG_W'(gga_pos_pkg::MICRO) +
                       gga_pos_pkg::MAG_W'(q4_ff[l]);
         mag_ext[l]  = {1'b0, mag5_ff[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) ok_ff[0] <= line_data.ok;
      for (int i = 1; i < Stages; i++) begin
         if (rdy[i]) ok_ff[i] <= ok_ff[i-1];
      end
      if (rdy[0]) begin
         whole0_ff[0] <= line_data.lat.whole;
         frac0_ff[0]  <= line_data.lat.frac;
         neg0_ff[0]   <= line_data.lat.neg;
         whole0_ff[1] <= line_data.lon.whole;
         frac0_ff[1]  <= line_data.lon.frac;
         neg0_ff[1]   <= line_data.lon.neg;
      end
      for (int l = 0; l < Lanes; l++) begin
         if (rdy[1]) begin
            deg1_ff[l]   <= deg_prod[l][gga_pos_pkg::DEG_SHIFT+gga_pos_pkg::DEG_W-1:
                                        gga_pos_pkg::DEG_SHIFT];
            whole1_ff[l] <= whole0_ff[l];
            frac1_ff[l]  <= frac0_ff[l];
            neg1_ff[l]   <= neg0_ff[l];
         end
         if (rdy[2]) begin
            deg2_ff[l]  <= deg1_ff[l];
            mm2_ff[l]   <= rem[l][gga_pos_pkg::MM_W-1:0];
            frac2_ff[l] <= frac1_ff[l];
            neg2_ff[l]  <= neg1_ff[l];
         end
         if (rdy[3]) begin
            deg3_ff[l] <= deg2_ff[l];
            x3_ff[l]   <= x_sum[l];
            neg3_ff[l] <= neg2_ff[l];
         end
         if (rdy[4]) begin
            deg4_ff[l] <= deg3_ff[l];
            q4_ff[l]   <= q_prod[l][gga_pos_pkg::RECIP15_SHIFT+gga_pos_pkg::Q_W-1:
                                    gga_pos_pkg::RECIP15_SHIFT];
            neg4_ff[l] <= neg3_ff[l];
         end
         if (rdy[5]) begin
            mag5_ff[l] <= mag_sum[l];
            neg5_ff[l] <= neg4_ff[l];
         end
         if (rdy[6]) begin
            if (!ok_ff[5]) begin
               out6_ff[l] <= '0;
            end else if (neg5_ff[l]) begin
               out6_ff[l] <= '0 - mag_ext[l];
            end else begin
               out6_ff[l] <= mag_ext[l];
            end
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[Stages-1];
   assign out_ok    = ok_ff[Stages-1];
   assign out_lat   = signed'(out6_ff[0]);
   assign out_lon   = signed'(out6_ff[1]);

   `GGA_POS_ASSERT_IMPL(a_fire_only_when_ready, line_fire, in_ready, "line beat while full")
   `GGA_POS_ASSERT_NEXT(a_entry_loaded, line_fire && rdy[0], v_ff[0], "entry stage not loaded")
   `GGA_POS_ASSERT_NEXT(a_out_follows, v_ff[5] && rdy[5],
                        v_ff[6] && ok_ff[6] == $past(ok_ff[5]), "output stage lost beat")
   `GGA_POS_ASSERT_IMPL(a_zero_invalid, v_ff[6] && !ok_ff[6],
                        out6_ff[0] == '0 && out6_ff[1] == '0, "invalid result not zero")

endmodule

// ===== rtl/core/gga_sentence_position_parser_top.sv =====
// Throughput: one byte per cycle while req_stall is low; the seven-stage conversion
// pipeline (stages 0 to 6, loaded by the newline beat that ends a line) holds up to
// seven results, and req_stall rises only when all are full and rsp_stall is high.
// Reset: synchronous, active high; clears the line parser state and pipeline valids.
module gga_sentence_position_parser_top #(
   parameter int FRACTION_DIGITS = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_rx_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [gga_pos_pkg::COORD_W-1:0] rsp_latitude_microdeg,
   output logic signed [gga_pos_pkg::COORD_W-1:0] rsp_longitude_microdeg,
   output logic                                    rsp_coords_valid
);

   logic                  in_ready;
   logic                  byte_fire;
   logic                  line_fire;
   gga_pos_pkg::line_type line_data;

   assign req_stall = !in_ready;
   assign byte_fire = req_valid && in_ready;

   gga_pos_parse #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .rx_byte   (req_rx_byte),
      .line_fire (line_fire),
      .line_data (line_data)
   );

   gga_pos_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .line_fire (line_fire),
      .line_data (line_data),
      .in_ready  (in_ready),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_lat   (rsp_latitude_microdeg),
      .out_lon   (rsp_longitude_microdeg),
      .out_ok    (rsp_coords_valid)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int          FRAC_DIGITS  = 5;
   localparam int          TAG_LEN      = 6;
   localparam int          WHOLE_MAX    = 5;
   localparam int          RANDOM_BYTES = 1500;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 30;
   localparam int          PRINT_CAP    = 100;

   localparam logic [7:0]  CH_NL    = 8'h0A;
   localparam logic [7:0]  CH_CR    = 8'h0D;
   localparam logic [7:0]  CH_COMMA = 8'h2C;
   localparam logic [7:0]  CH_DOT   = 8'h2E;
   localparam logic [7:0]  CH_ZERO  = 8'h30;
   localparam logic [7:0]  CH_NINE  = 8'h39;
   localparam logic [7:0]  CH_N     = 8'h4E;
   localparam logic [7:0]  CH_S     = 8'h53;
   localparam logic [7:0]  CH_E     = 8'h45;
   localparam logic [7:0]  CH_W     = 8'h57;
   localparam logic [47:0] GGA_TAG  = "$GPGGA";

   localparam logic [3:0]  F_ID   = 4'd0;
   localparam logic [3:0]  F_LAT  = 4'd2;
   localparam logic [3:0]  F_NS   = 4'd3;
   localparam logic [3:0]  F_LON  = 4'd4;
   localparam logic [3:0]  F_EW   = 4'd5;
   localparam logic [3:0]  F_LAST = 4'd15;

   typedef enum logic [1:0] {NUM_WHOLE, NUM_FRAC, NUM_STOP} num_phase_type;
   typedef enum int {ROW_PREDICTED, ROW_RESULT, ROW_SILENT} row_kind_type;

   typedef struct packed {
      logic [30:0] lat;
      logic [30:0] lon;
      logic        ok;
   } fix_type;

   localparam int N_DIR = 17;

   string dir_text [N_DIR] = '{
      "$GPGGA\n",
      "\n",
      "$GPGGA,,0000,N,00000,E\n",
      "$GPGGA,,.,N,x,E\n",
      "$GPGGA,,9959.99999,S,17959.99999,W\n",
      "$GPGGA,,99999.99999,N,99999.99999,E\n",
      "$GPGGA,,99999.99999,S,99999.99999,W\n",
      "$GPGGA,,123456,N,1,E\n",
      "$GPGGA,,1,N,,E\n",
      "$GPGGA,,1,N,1\n",
      "$GPGGB,,1,N,1,E\n",
      "$GPGGAA,,1,N,1,E\n",
      "$GPGG,,1,N,1,E\n",
      "$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n",
      "$GPGGA,,4807.0381234,SS,x1.5,w\n",
      "$GPGGA,,12.3.4,S,-7,W,,,,,,,,,,,,,,,,,,\n",
      "$GPGGA,,0030.00001,N,0000.00003,E\015\n"
   };
   row_kind_type dir_kind [N_DIR] = '{
      ROW_RESULT, ROW_SILENT, ROW_RESULT, ROW_RESULT, ROW_RESULT, ROW_RESULT,
      ROW_RESULT, ROW_RESULT, ROW_RESULT, ROW_RESULT, ROW_SILENT, ROW_SILENT,
      ROW_SILENT, ROW_PREDICTED, ROW_PREDICTED, ROW_PREDICTED, ROW_PREDICTED
   };
   int dir_lat [N_DIR] = '{0, 0, 0, 0, -100000000, 1000666667, -1000666667,
                           0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
   int dir_lon [N_DIR] = '{0, 0, 0, 0, -180000000, 1000666667, -1000666667,
                           0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
   bit dir_ok  [N_DIR] = '{0, 0, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic signed [30:0] rsp_latitude_microdeg;
   logic signed [30:0] rsp_longitude_microdeg;
   logic               rsp_coords_valid;

   gga_sentence_position_parser_top #(
      .FRACTION_DIGITS(FRAC_DIGITS)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_latitude_microdeg (rsp_latitude_microdeg),
      .rsp_longitude_microdeg(rsp_longitude_microdeg),
      .rsp_coords_valid      (rsp_coords_valid)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   int unsigned cycle_count = 0;
   int          fail_count  = 0;
   int          send_idle_pct = 30;
   int          stall_pct     = 55;
   bit          predict_on    = 1'b1;
   fix_type     fix_q [$];
   logic [7:0]  line_bytes [$];

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // line parser state
   logic [3:0]    fld_idx;
   logic [2:0]    id_pos;
   logic          id_ok;
   logic [16:0]   whole_acc;
   logic [19:0]   frac_acc;
   logic [2:0]    frac_cnt;
   logic [2:0]    whole_cnt;
   num_phase_type num_phase;
   logic          fld_bad;
   logic          fld_used;
   logic [16:0]   lat_w;
   logic [19:0]   lat_f;
   logic          lat_good;
   logic [16:0]   lon_w;
   logic [19:0]   lon_f;
   logic          lon_good;
   logic [7:0]    ind_char;
   logic [1:0]    ind_len;
   logic          is_south;
   logic          is_west;

   function automatic longint unsigned pow10(int n);
      longint unsigned p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   function automatic logic [30:0] to_microdeg(logic [16:0] whole, logic [19:0] frac,
                                               logic neg);
      longint unsigned scale, minutes, mag;
      scale   = pow10(FRAC_DIGITS);
      minutes = 64'(whole % 100) * scale + 64'(frac);
      mag     = 64'(whole / 100) * 1000000 + (minutes * 1000000 + 30 * scale) / (60 * scale);
      if (neg)
         mag = -mag;
      return mag[30:0];
   endfunction

   task automatic restart_field();
      whole_acc = '0;
      frac_acc  = '0;
      frac_cnt  = '0;
      whole_cnt = '0;
      num_phase = NUM_WHOLE;
      fld_bad   = 1'b0;
      fld_used  = 1'b0;
      ind_char  = '0;
      ind_len   = '0;
   endtask

   task automatic restart_line();
      fld_idx  = '0;
      id_pos   = '0;
      id_ok    = 1'b1;
      lat_w    = '0;
      lat_f    = '0;
      lat_good = 1'b0;
      lon_w    = '0;
      lon_f    = '0;
      lon_good = 1'b0;
      is_south = 1'b0;
      is_west  = 1'b0;
      restart_field();
   endtask

   task automatic close_field();
      logic [19:0] scaled;
      logic        good;
      scaled = 20'(64'(frac_acc) * pow10(FRAC_DIGITS - int'(frac_cnt)));
      good   = fld_used && !fld_bad;
      case (fld_idx)
         F_ID: begin
            if (id_pos != TAG_LEN)
               id_ok = 1'b0;
         end
         F_LAT: begin
            lat_w    = whole_acc;
            lat_f    = scaled;
            lat_good = good;
         end
         F_NS: is_south = (ind_len == 2'd1) && (ind_char == CH_S);
         F_LON: begin
            lon_w    = whole_acc;
            lon_f    = scaled;
            lon_good = good;
         end
         F_EW: is_west = (ind_len == 2'd1) && (ind_char == CH_W);
         default: ;
      endcase
   endtask

   task automatic take_char(logic [7:0] b);
      logic is_digit;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      fld_used = 1'b1;
      if (fld_idx == F_ID) begin
         if (id_pos >= TAG_LEN)
            id_ok = 1'b0;
         else if (b != GGA_TAG[8*(TAG_LEN-1-int'(id_pos)) +: 8])
            id_ok = 1'b0;
         if (id_pos != 3'd7)
            id_pos = id_pos + 3'd1;
      end else if (fld_idx == F_LAT || fld_idx == F_LON) begin
         case (num_phase)
            NUM_WHOLE: begin
               if (is_digit) begin
                  if (whole_cnt >= WHOLE_MAX) begin
                     fld_bad   = 1'b1;
                     num_phase = NUM_STOP;
                  end else begin
                     whole_acc = 17'(whole_acc * 10 + (b - CH_ZERO));
                     whole_cnt = whole_cnt + 3'd1;
                  end
               end else if (b == CH_DOT) begin
                  num_phase = NUM_FRAC;
               end else begin
                  num_phase = NUM_STOP;
               end
            end
            NUM_FRAC: begin
               if (is_digit) begin
                  if (frac_cnt < FRAC_DIGITS) begin
                     frac_acc = 20'(frac_acc * 10 + (b - CH_ZERO));
                     frac_cnt = frac_cnt + 3'd1;
                  end
               end else begin
                  num_phase = NUM_STOP;
               end
            end
            default: ;
         endcase
      end else if (fld_idx == F_NS || fld_idx == F_EW) begin
         if (ind_len == 2'd0)
            ind_char = b;
         if (ind_len != 2'd2)
            ind_len = ind_len + 2'd1;
      end
   endtask

   task automatic parse_byte(logic [7:0] b);
      fix_type f;
      if (b == CH_NL) begin
         close_field();
         if (id_ok && predict_on) begin
            f.ok  = (fld_idx >= F_EW) && lat_good && lon_good;
            f.lat = f.ok ? to_microdeg(lat_w, lat_f, is_south) : '0;
            f.lon = f.ok ? to_microdeg(lon_w, lon_f, is_west) : '0;
            fix_q.push_back(f);
         end
         restart_line();
      end else if (b == CH_COMMA) begin
         close_field();
         if (fld_idx != F_LAST)
            fld_idx = fld_idx + 4'd1;
         restart_field();
      end else begin
         take_char(b);
      end
   endtask

   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_fix();
      fix_type want;
      if (fix_q.size() == 0) begin
         report_mismatch("result beat with nothing pending");
         return;
      end
      want = fix_q.pop_front();
      if (rsp_latitude_microdeg !== want.lat)
         report_mismatch($sformatf("latitude %0d, want %0d",
                                   rsp_latitude_microdeg, $signed(want.lat)));
      if (rsp_longitude_microdeg !== want.lon)
         report_mismatch($sformatf("longitude %0d, want %0d",
                                   rsp_longitude_microdeg, $signed(want.lon)));
      if (rsp_coords_valid !== want.ok)
         report_mismatch($sformatf("coords_valid %b, want %b", rsp_coords_valid, want.ok));
   endtask

   // result side: sample mid-cycle, take the beat at the next edge
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_fix();
         @(posedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_byte(logic [7:0] b);
      logic taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         taken = !req_stall;
         if (taken)
            parse_byte(b);
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_line();
      foreach (line_bytes[k])
         send_byte(line_bytes[k]);
   endtask

   task automatic push_str(string s);
      for (int k = 0; k < s.len(); k++)
         line_bytes.push_back(s[k]);
   endtask

   task automatic add_digits(int n, bit nines);
      repeat (n)
         line_bytes.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_coord(int whole_len);
      int style, n;
      bit nines;
      style = $urandom_range(0, 19);
      nines = (style == 4);
      case (style)
         0: ;
         1: add_digits($urandom_range(6, 8), 1'b0);
         2: begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
            add_digits(3, 1'b0);
         end
         3: begin
            add_digits(whole_len, 1'b0);
            line_bytes.push_back(CH_DOT);
            add_digits(2, 1'b0);
            line_bytes.push_back(CH_DOT);
            add_digits(2, 1'b0);
         end
         default: begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WHOLE_MAX) : whole_len;
            add_digits(n, nines);
            if ($urandom_range(0, 9) != 0) begin
               line_bytes.push_back(CH_DOT);
               add_digits($urandom_range(0, 8), nines);
            end
         end
      endcase
   endtask

   task automatic add_indicator(logic [7:0] pos, logic [7:0] neg);
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            line_bytes.push_back(neg);
            line_bytes.push_back(neg);
         end
         2: line_bytes.push_back(8'($urandom_range(0, 255)));
         default: line_bytes.push_back($urandom_range(0, 1) ? neg : pos);
      endcase
   endtask

   task automatic build_line();
      int r, last_fld;
      line_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 20))
            line_bytes.push_back(8'($urandom_range(0, 255)));
         line_bytes.push_back(CH_NL);
         return;
      end
      if (r < 14) begin
         case ($urandom_range(0, 3))
            0: push_str("$GPRMC");
            1: push_str("$GPGG");
            2: push_str("$GPGGAA");
            default: begin
               push_str("$GPGGA");
               line_bytes[$urandom_range(0, TAG_LEN - 1)] = 8'($urandom_range(0, 255));
            end
         endcase
      end else begin
         push_str("$GPGGA");
      end
      last_fld = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5;
      if (last_fld >= 1) begin
         line_bytes.push_back(CH_COMMA);
         add_digits($urandom_range(0, 6), 1'b0);
      end
      if (last_fld >= 2) begin
         line_bytes.push_back(CH_COMMA);
         add_coord(4);
      end
      if (last_fld >= 3) begin
         line_bytes.push_back(CH_COMMA);
         add_indicator(CH_N, CH_S);
      end
      if (last_fld >= 4) begin
         line_bytes.push_back(CH_COMMA);
         add_coord(5);
      end
      if (last_fld >= 5) begin
         line_bytes.push_back(CH_COMMA);
         add_indicator(CH_E, CH_W);
         repeat ($urandom_range(0, 14)) begin
            line_bytes.push_back(CH_COMMA);
            add_digits($urandom_range(0, 3), 1'b0);
         end
      end
      if ($urandom_range(0, 3) == 0)
         line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_NL);
   endtask

   initial begin
      int sent;
      restart_line();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         predict_on = (dir_kind[i] == ROW_PREDICTED);
         if (dir_kind[i] == ROW_RESULT)
            fix_q.push_back(fix_type'{lat: dir_lat[i][30:0], lon: dir_lon[i][30:0],
                                      ok: dir_ok[i]});
         line_bytes.delete();
         push_str(dir_text[i]);
         send_line();
      end
      predict_on = 1'b1;

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 30 : (p == 1) ? 55 : 0;
         stall_pct     = (p == 0) ? 55 : (p == 1) ? 30 : 0;
         sent = 0;
         while (sent < RANDOM_BYTES / 3) begin
            build_line();
            sent += line_bytes.size();
            send_line();
         end
      end
      req_valid <= 1'b0;

      while (fix_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
